### rtl/admittance_filter_six_axis_core_assert.svh
// assertion macros for the admittance filter core
`ifndef ADMITTANCE_FILTER_SIX_AXIS_CORE_ASSERT_SVH
`define ADMITTANCE_FILTER_SIX_AXIS_CORE_ASSERT_SVH

// implication checked every clock outside reset
`define AF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked every clock outside reset
`define AF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/afsa_pkg.sv
`timescale 1ns / 1ps
package afsa_pkg;
    localparam int DEF_NUM_AXES    = 6;
    localparam int DEF_VALUE_WIDTH = 32;
    localparam int FRAC            = 16;
    localparam int IO_W            = 32;

    localparam logic CMD_STEP = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_LOADED = 2'd1;
    localparam logic [1:0] ST_SAT    = 2'd2;
    localparam logic [1:0] ST_ZERO   = 2'd3;

    localparam logic [1:0] ORD_STIFF = 2'd0;
    localparam logic [1:0] ORD_DAMP  = 2'd1;

    localparam logic CFG_ORDER = 1'b0;
    localparam logic CFG_MASK  = 1'b1;

    // datapath operations, one per sequencer step
    typedef enum logic [4:0] {
        OP_NONE  = 5'd0,
        OP_LATCH = 5'd1,  // latch item inputs
        OP_MUL   = 5'd2,  // r_p = a * b >> 16 with saturation
        OP_ADD   = 5'd3,  // r_acc = sel + sel
        OP_SUB   = 5'd4,
        OP_SQRT  = 5'd5,  // one step of integer square root
        OP_DIV   = 5'd6,  // one step of restoring division
        OP_MOV   = 5'd7,
        OP_WR    = 5'd8,  // write back registers
        OP_INIT  = 5'd9
    } t_op;

    // operand selects
    typedef enum logic [3:0] {
        SEL_ZERO = 4'd0, SEL_XD = 4'd1, SEL_VD = 4'd2, SEL_AD = 4'd3,
        SEL_F = 4'd4, SEL_DT = 4'd5, SEL_XC = 4'd6, SEL_VC = 4'd7,
        SEL_K = 4'd8, SEL_D = 4'd9, SEL_IM = 4'd10, SEL_IK = 4'd11,
        SEL_ID = 4'd12, SEL_ACC = 4'd13, SEL_P = 4'd14, SEL_T = 4'd15
    } t_sel;

    typedef struct packed {
        t_op  op;
        t_sel sa;
        t_sel sb;
        logic to_t;     // copy result into temp
        logic to_v;     // copy result into v
        logic to_x;
        logic to_a;
        logic [1:0] dsrc; // divide source 0 m 1 k 2 d
        logic [1:0] ddst; // same coding for destination
    } t_cmd;

    typedef struct packed {
        logic       is_load;
        logic       bad_axis;
        logic       compliant;
        logic       zero_k;
        logic       zero_d;
        logic       zero_im;
        logic       done_iter;
    } t_stat;
endpackage

### rtl/admittance_filter_six_axis_core.sv
`timescale 1ns / 1ps
// step item: an out-of-range axis goes straight to write-back; a pass-through step
// runs no operations; order 0, 1, or 2 and 3 runs the law on the shared
// multiply/add unit, one operation per cycle
// load item: a 32-step square root and three 33-step restoring reciprocal
// divisions; one item in flight
// synchronous active-low reset clears config, control and all per-axis state
`include "admittance_filter_six_axis_core_assert.svh"
module admittance_filter_six_axis_core
    import afsa_pkg::*;
#(
    parameter int NUM_AXES    = DEF_NUM_AXES,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_index,
    input  logic [5:0]      i_cfg_data,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic            i_command,
    input  logic [2:0]      i_axis,
    input  logic [IO_W-1:0] i_position_ref,
    input  logic [IO_W-1:0] i_velocity_ref,
    input  logic [IO_W-1:0] i_accel_ref,
    input  logic [IO_W-1:0] i_force_meas,
    input  logic [IO_W-1:0] i_time_step,
    input  logic [IO_W-1:0] i_mass_gain,
    input  logic [IO_W-1:0] i_stiffness_gain,
    input  logic [IO_W-1:0] i_damping_ratio,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [2:0]      o_axis_out,
    output logic [IO_W-1:0] o_position_cmd,
    output logic [IO_W-1:0] o_velocity_cmd,
    output logic [IO_W-1:0] o_accel_cmd,
    output logic [1:0]      o_status
);
    logic [1:0] r_order;
    logic [5:0] r_mask;
    t_cmd  w_cmd;
    t_stat w_stat;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= '0; r_mask <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_ORDER) r_order <= i_cfg_data[1:0];
            else                          r_mask  <= i_cfg_data;
        end
    end

    afsa_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .o_valid, .i_stall,
        .i_order(r_order), .i_stat(w_stat), .o_cmd(w_cmd)
    );

    afsa_datapath #(.NUM_AXES(NUM_AXES), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_stat(w_stat),
        .i_order(r_order), .i_mask(r_mask),
        .i_command, .i_axis, .i_position_ref, .i_velocity_ref, .i_accel_ref,
        .i_force_meas, .i_time_step, .i_mass_gain, .i_stiffness_gain,
        .i_damping_ratio, .o_axis_out, .o_position_cmd, .o_velocity_cmd,
        .o_accel_cmd, .o_status
    );

    // checks
    `AF_ASSERT_IMP(a_busy_stalls, o_valid, o_stall)
    `AF_ASSERT_NXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_position_cmd))
    `AF_ASSERT_NXT(a_accept_busy, i_valid && !o_stall, o_stall && !o_valid)
endmodule

### rtl/afsa_datapath.sv
`timescale 1ns / 1ps
module afsa_datapath
    import afsa_pkg::*;
#(
    parameter int NUM_AXES    = DEF_NUM_AXES,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_stat            o_stat,
    input  logic [1:0]       i_order,
    input  logic [5:0]       i_mask,
    input  logic             i_command,
    input  logic [2:0]       i_axis,
    input  logic [IO_W-1:0]  i_position_ref,
    input  logic [IO_W-1:0]  i_velocity_ref,
    input  logic [IO_W-1:0]  i_accel_ref,
    input  logic [IO_W-1:0]  i_force_meas,
    input  logic [IO_W-1:0]  i_time_step,
    input  logic [IO_W-1:0]  i_mass_gain,
    input  logic [IO_W-1:0]  i_stiffness_gain,
    input  logic [IO_W-1:0]  i_damping_ratio,
    output logic [2:0]       o_axis_out,
    output logic [IO_W-1:0]  o_position_cmd,
    output logic [IO_W-1:0]  o_velocity_cmd,
    output logic [IO_W-1:0]  o_accel_cmd,
    output logic [1:0]       o_status
);
    localparam int W   = VALUE_WIDTH;
    localparam int AW  = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
    localparam int MW  = 2 * W;
    localparam int DW  = 2 * FRAC + 1;  // dividend width for 2^32
    localparam int QW  = (DW > W) ? DW : W;
    localparam int CW  = $clog2(QW + 1) + 1;
    localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

    // per-axis state, small register files
    logic signed [W-1:0] r_pos [NUM_AXES];
    logic signed [W-1:0] r_vel [NUM_AXES];
    logic signed [W-1:0] r_im  [NUM_AXES];
    logic signed [W-1:0] r_k   [NUM_AXES];
    logic signed [W-1:0] r_d   [NUM_AXES];
    logic signed [W-1:0] r_ik  [NUM_AXES];
    logic signed [W-1:0] r_id  [NUM_AXES];

    logic [AW-1:0] r_ax;
    logic [2:0] r_axis_raw;
    logic r_load, r_bad, r_comp, r_sat;
    logic signed [W-1:0] r_xd, r_vd, r_ad, r_f, r_dt, r_xc, r_vc;
    logic signed [W-1:0] r_kc, r_dc, r_imc, r_ikc, r_idc;
    logic signed [W-1:0] r_acc, r_p, r_t, r_x, r_v, r_a;
    logic [IO_W-1:0] r_m, r_kg, r_z;
    logic [1:0] r_st;

    // sqrt and divide working registers
    logic [MW-1:0] r_rem, r_root, r_bit;
    logic [QW-1:0] r_dvd, r_q;
    logic [MW-1:0] r_dr;
    logic [CW-1:0] r_cnt;

    // sign extend and clamp of a 32-bit input
    function automatic logic signed [W-1:0] sx(input logic [IO_W-1:0] r, output logic s);
        logic signed [IO_W:0] e;
        begin
            e = $signed({r[IO_W-1], r});
            s = 1'b0;
            if (IO_W + 1 > W && e > $signed((IO_W+1)'(VMAX))) begin
                s = 1'b1; sx = VMAX;
            end else if (IO_W + 1 > W && e < $signed((IO_W+1)'(VMIN))) begin
                s = 1'b1; sx = VMIN;
            end else begin
                sx = W'(e);
            end
        end
    endfunction

    logic s0, s1, s2, s3;
    logic signed [W-1:0] w_xd, w_vd, w_ad, w_f;
    always_comb begin
        w_xd = sx(i_position_ref, s0);
        w_vd = sx(i_velocity_ref, s1);
        w_ad = sx(i_accel_ref, s2);
        w_f  = sx(i_force_meas, s3);
    end

    function automatic logic signed [W-1:0] pick(input t_sel s,
        input logic signed [W-1:0] xd, vd, ad, f, dt, xc, vc, k, d, im, ik, id,
        acc, p, t);
        case (s)
            SEL_XD: pick = xd;  SEL_VD: pick = vd;  SEL_AD: pick = ad;
            SEL_F: pick = f;    SEL_DT: pick = dt;  SEL_XC: pick = xc;
            SEL_VC: pick = vc;  SEL_K: pick = k;    SEL_D: pick = d;
            SEL_IM: pick = im;  SEL_IK: pick = ik;  SEL_ID: pick = id;
            SEL_ACC: pick = acc; SEL_P: pick = p;   SEL_T: pick = t;
            default: pick = '0;
        endcase
    endfunction

    logic signed [W-1:0] w_a, w_b;
    assign w_a = pick(i_cmd.sa, r_xd, r_vd, r_ad, r_f, r_dt, r_xc, r_vc, r_kc, r_dc,
                      r_imc, r_ikc, r_idc, r_acc, r_p, r_t);
    assign w_b = pick(i_cmd.sb, r_xd, r_vd, r_ad, r_f, r_dt, r_xc, r_vc, r_kc, r_dc,
                      r_imc, r_ikc, r_idc, r_acc, r_p, r_t);

    // saturating add and subtract
    logic signed [W:0] w_sum, w_dif;
    logic signed [W-1:0] w_addr, w_subr;
    logic w_adds, w_subs;
    assign w_sum = $signed({w_a[W-1], w_a}) + $signed({w_b[W-1], w_b});
    assign w_dif = $signed({w_a[W-1], w_a}) - $signed({w_b[W-1], w_b});
    always_comb begin
        w_adds = (w_sum[W] != w_sum[W-1]);
        w_addr = w_adds ? (w_sum[W] ? VMIN : VMAX) : w_sum[W-1:0];
        w_subs = (w_dif[W] != w_dif[W-1]);
        w_subr = w_subs ? (w_dif[W] ? VMIN : VMAX) : w_dif[W-1:0];
    end

    // Q16.16 product on magnitudes, truncated toward zero
    logic w_neg, w_bu;
    logic [W-1:0] w_ua, w_ub;
    logic [MW-1:0] w_prod, w_q;
    logic [W-1:0] w_lim;
    logic signed [W-1:0] w_mulr;
    logic w_muls;
    always_comb begin
        // time step is unsigned, and the load product of z and the root is unsigned
        w_bu   = (i_cmd.sb == SEL_DT);
        w_neg  = !r_load && (w_a[W-1] ^ (w_b[W-1] && !w_bu));
        w_ua   = r_load ? W'(r_z) : (w_a[W-1] ? W'(-w_a) : w_a);
        w_ub   = r_load ? W'(r_root) : ((w_b[W-1] && !w_bu) ? W'(-w_b) : w_b);
        w_prod = MW'(w_ua) * MW'(w_ub);
        w_q    = w_prod >> FRAC;
        w_lim  = w_neg ? (W'(VMAX) + W'(1)) : W'(VMAX);
        w_muls = (w_q[MW-1:W] != '0) || (w_q[W-1:0] > w_lim);
        if (w_muls) w_mulr = w_neg ? VMIN : VMAX;
        else        w_mulr = w_neg ? W'(-w_q[W-1:0]) : w_q[W-1:0];
    end

    logic [MW-1:0] w_trial;
    logic [MW:0] w_dtrial;
    assign w_trial  = r_root + r_bit;
    assign w_dtrial = {r_rem[MW-1:0], r_dvd[QW-1]} ;

    logic w_zk, w_zd, w_zi;
    assign w_zk = (r_k[r_ax] == '0);
    assign w_zd = (r_d[r_ax] == '0);
    assign w_zi = (r_im[r_ax] == '0);

    assign o_stat = '{is_load: r_load, bad_axis: r_bad, compliant: r_comp,
                      zero_k: (r_kc == '0), zero_d: (r_dc == '0), zero_im: (r_imc == '0),
                      done_iter: (r_cnt == '0)};

    logic signed [W-1:0] w_res;
    always_comb begin
        case (i_cmd.op)
            OP_ADD:  w_res = w_addr;
            OP_SUB:  w_res = w_subr;
            OP_MUL:  w_res = w_mulr;
            default: w_res = w_a;
        endcase
    end

    // gain clamp of an unsigned QW-bit value
    function automatic logic signed [W-1:0] gcl(input logic [QW-1:0] g);
        if (g > QW'(VMAX)) gcl = VMAX;
        else               gcl = W'(g);
    endfunction

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LATCH: begin
                r_axis_raw <= i_axis;
                r_ax  <= AW'(i_axis);
                r_bad <= (32'(i_axis) >= NUM_AXES);
                r_load <= (i_command == CMD_LOAD);
                r_comp <= (32'(i_axis) < 6) && i_mask[i_axis];
                r_xd <= w_xd; r_vd <= w_vd; r_ad <= w_ad; r_f <= w_f;
                r_dt <= W'($signed({1'b0, i_time_step}));
                r_sat <= s0 | s1 | s2 | s3;
                r_m <= i_mass_gain; r_kg <= i_stiffness_gain; r_z <= i_damping_ratio;
                r_x <= w_xd; r_v <= w_vd; r_a <= w_ad;
                r_st <= ST_OK;
            end
            OP_INIT: begin
                // snapshot axis state, prime square root of m*k
                if (!r_bad) begin
                    r_xc <= r_pos[r_ax]; r_vc <= r_vel[r_ax];
                    r_kc <= r_k[r_ax]; r_dc <= r_d[r_ax]; r_imc <= r_im[r_ax];
                    r_ikc <= r_ik[r_ax]; r_idc <= r_id[r_ax];
                end
                r_rem  <= MW'(r_m) * MW'(r_kg);
                r_root <= '0;
                r_bit  <= MW'(1) << (MW - 2);
                r_cnt  <= CW'(MW / 2);
                if (r_comp && !r_load) begin
                    case (i_order)
                        ORD_STIFF: if (w_zk) r_st <= ST_ZERO;
                        ORD_DAMP:  if (w_zd) r_st <= ST_ZERO;
                        default:   if (w_zi) r_st <= ST_ZERO;
                    endcase
                end
            end
            OP_SQRT: begin
                if (r_rem >= w_trial) begin
                    r_rem  <= r_rem - w_trial;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    // operands for d = z * sqrt
                    r_kc <= W'($signed({1'b0, r_z}));
                end
            end
            OP_MUL, OP_ADD, OP_SUB, OP_MOV: begin
                r_acc <= w_res;
                r_p   <= w_res;
                if (!r_load && (w_muls && i_cmd.op == OP_MUL || w_adds && i_cmd.op == OP_ADD
                    || w_subs && i_cmd.op == OP_SUB)) r_sat <= 1'b1;
                if (i_cmd.to_t) r_t <= w_res;
                if (i_cmd.to_v) r_v <= w_res;
                if (i_cmd.to_x) r_x <= w_res;
                if (i_cmd.to_a) r_a <= w_res;
                // doubled damping of a load
                if (r_load && i_cmd.op == OP_ADD) r_dc <= w_res;
            end
            OP_DIV: begin
                if (r_cnt == '0) begin
                    // load divider: 2^32 / source
                    r_dvd <= QW'(1) << (2 * FRAC);
                    r_q   <= '0;
                    r_rem <= '0;
                    case (i_cmd.dsrc)
                        2'd0: r_dr <= MW'(r_m);
                        2'd1: r_dr <= MW'(r_kg);
                        default: r_dr <= MW'(unsigned'(r_dc));
                    endcase
                    r_cnt <= CW'(QW);
                end else begin
                    if (w_dtrial >= {1'b0, r_dr}) begin
                        r_rem <= MW'(w_dtrial - {1'b0, r_dr});
                        r_q   <= {r_q[QW-2:0], 1'b1};
                    end else begin
                        r_rem <= w_dtrial[MW-1:0];
                        r_q   <= {r_q[QW-2:0], 1'b0};
                    end
                    r_dvd <= r_dvd << 1;
                    r_cnt <= r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        case (i_cmd.ddst)
                            2'd0: r_imc <= (r_dr == '0) ? '0 :
                                gcl({r_q[QW-2:0], (w_dtrial >= {1'b0, r_dr})});
                            2'd1: r_ikc <= (r_dr == '0) ? '0 :
                                gcl({r_q[QW-2:0], (w_dtrial >= {1'b0, r_dr})});
                            default: r_idc <= (r_dr == '0) ? '0 :
                                gcl({r_q[QW-2:0], (w_dtrial >= {1'b0, r_dr})});
                        endcase
                    end
                end
            end
            default: ;
        endcase
        // square root result feeds the damping product
        if (i_cmd.op == OP_SQRT && r_cnt == CW'(1)) begin
            r_p <= (r_rem >= w_trial) ? gcl(QW'((r_root >> 1) + r_bit))
                                      : gcl(QW'(r_root >> 1));
        end
    end

    // register file write-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                r_pos[i] <= '0; r_vel[i] <= '0; r_im[i] <= '0; r_k[i] <= '0;
                r_d[i] <= '0; r_ik[i] <= '0; r_id[i] <= '0;
            end
        end else if (i_cmd.op == OP_WR && !r_bad) begin
            if (r_load) begin
                r_k[r_ax]  <= gcl(QW'(r_kg));
                r_d[r_ax]  <= r_dc;
                r_im[r_ax] <= r_imc;
                r_ik[r_ax] <= r_ikc;
                r_id[r_ax] <= r_idc;
            end else begin
                r_pos[r_ax] <= r_x;
                r_vel[r_ax] <= r_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_WR) begin
            o_axis_out <= r_axis_raw;
            if (r_bad) begin
                o_position_cmd <= '0; o_velocity_cmd <= '0; o_accel_cmd <= '0;
                o_status <= ST_ZERO;
            end else if (r_load) begin
                o_position_cmd <= IO_W'(r_pos[r_ax]);
                o_velocity_cmd <= IO_W'(r_vel[r_ax]);
                o_accel_cmd <= '0;
                o_status <= ST_LOADED;
            end else begin
                o_position_cmd <= IO_W'(r_x);
                o_velocity_cmd <= IO_W'(r_v);
                o_accel_cmd <= IO_W'(r_a);
                o_status <= (r_st == ST_ZERO) ? ST_ZERO : (r_sat ? ST_SAT : ST_OK);
            end
        end
    end
endmodule

### rtl/afsa_ctrl.sv
`timescale 1ns / 1ps
module afsa_ctrl
    import afsa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    output logic       o_valid,
    input  logic       i_stall,
    input  logic [1:0] i_order,
    input  t_stat      i_stat,
    output t_cmd       o_cmd
);
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001, S_INIT = 7'b0000010, S_SQRT = 7'b0000100,
        S_DIV  = 7'b0001000, S_STEP = 7'b0010000, S_WR   = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [3:0] r_pc, n_pc;
    logic [1:0] r_dix, n_dix;
    logic r_dbusy, n_dbusy;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);

    // micro-program for compliant steps, selected by the filter order
    function automatic t_cmd prog(input logic [1:0] ord, input logic [3:0] pc);
        t_cmd c;
        c = '{op: OP_NONE, sa: SEL_ZERO, sb: SEL_ZERO, to_t: 1'b0, to_v: 1'b0,
              to_x: 1'b0, to_a: 1'b0, dsrc: 2'd0, ddst: 2'd0};
        if (ord == ORD_STIFF) begin
            case (pc)
                4'd0: begin c.op = OP_MUL; c.sa = SEL_IK; c.sb = SEL_F; end
                4'd1: begin c.op = OP_ADD; c.sa = SEL_XD; c.sb = SEL_P; c.to_x = 1'b1; end
                default: ;
            endcase
        end else if (ord == ORD_DAMP) begin
            case (pc)
                4'd0: begin c.op = OP_SUB; c.sa = SEL_XD; c.sb = SEL_XC; end
                4'd1: begin c.op = OP_MUL; c.sa = SEL_K; c.sb = SEL_ACC; end
                4'd2: begin c.op = OP_ADD; c.sa = SEL_F; c.sb = SEL_P; end
                4'd3: begin c.op = OP_MUL; c.sa = SEL_ID; c.sb = SEL_ACC; end
                4'd4: begin c.op = OP_ADD; c.sa = SEL_VD; c.sb = SEL_P; c.to_v = 1'b1;
                            c.to_t = 1'b1; end
                4'd5: begin c.op = OP_MUL; c.sa = SEL_T; c.sb = SEL_DT; end
                4'd6: begin c.op = OP_ADD; c.sa = SEL_XC; c.sb = SEL_P; c.to_x = 1'b1; end
                default: ;
            endcase
        end else begin
            case (pc)
                4'd0:  begin c.op = OP_SUB; c.sa = SEL_VD; c.sb = SEL_VC; end
                4'd1:  begin c.op = OP_MUL; c.sa = SEL_D; c.sb = SEL_ACC; end
                4'd2:  begin c.op = OP_ADD; c.sa = SEL_F; c.sb = SEL_P; c.to_t = 1'b1; end
                4'd3:  begin c.op = OP_SUB; c.sa = SEL_XD; c.sb = SEL_XC; end
                4'd4:  begin c.op = OP_MUL; c.sa = SEL_K; c.sb = SEL_ACC; end
                4'd5:  begin c.op = OP_ADD; c.sa = SEL_T; c.sb = SEL_P; end
                4'd6:  begin c.op = OP_MUL; c.sa = SEL_IM; c.sb = SEL_ACC; end
                4'd7:  begin c.op = OP_ADD; c.sa = SEL_AD; c.sb = SEL_P; c.to_a = 1'b1;
                             c.to_t = 1'b1; end
                4'd8:  begin c.op = OP_MUL; c.sa = SEL_T; c.sb = SEL_DT; end
                4'd9:  begin c.op = OP_ADD; c.sa = SEL_VC; c.sb = SEL_P; c.to_v = 1'b1;
                             c.to_t = 1'b1; end
                4'd10: begin c.op = OP_MUL; c.sa = SEL_T; c.sb = SEL_DT; end
                4'd11: begin c.op = OP_ADD; c.sa = SEL_XC; c.sb = SEL_P; c.to_x = 1'b1; end
                default: ;
            endcase
        end
        return c;
    endfunction

    function automatic logic [3:0] plen(input logic [1:0] ord);
        case (ord)
            ORD_STIFF: plen = 4'd2;
            ORD_DAMP:  plen = 4'd7;
            default:   plen = 4'd12;
        endcase
    endfunction

    logic w_zero;
    always_comb begin
        case (i_order)
            ORD_STIFF: w_zero = i_stat.zero_k;
            ORD_DAMP:  w_zero = i_stat.zero_d;
            default:   w_zero = i_stat.zero_im;
        endcase
    end

    always_comb begin
        n_state = r_state; n_pc = r_pc; n_dix = r_dix; n_dbusy = r_dbusy;
        o_cmd = '{op: OP_NONE, sa: SEL_ZERO, sb: SEL_ZERO, to_t: 1'b0, to_v: 1'b0,
                  to_x: 1'b0, to_a: 1'b0, dsrc: 2'd0, ddst: 2'd0};
        case (r_state)
            S_IDLE: begin
                o_cmd.op = OP_LATCH;
                if (i_valid) n_state = S_INIT;
            end
            S_INIT: begin
                o_cmd.op = OP_INIT;
                n_pc = '0;
                if (i_stat.bad_axis) n_state = S_WR;
                else if (i_stat.is_load) n_state = S_SQRT;
                else n_state = S_STEP;
            end
            S_SQRT: begin
                if (i_stat.done_iter) begin
                    // d = 2 * (z * sqrt(m*k))
                    case (r_pc)
                        4'd0: begin o_cmd.op = OP_MUL; o_cmd.sa = SEL_K; o_cmd.sb = SEL_P;
                                    n_pc = 4'd1; end
                        default: begin
                            o_cmd.op = OP_ADD; o_cmd.sa = SEL_ACC; o_cmd.sb = SEL_ACC;
                            n_pc = '0; n_dix = 2'd0; n_dbusy = 1'b0; n_state = S_DIV;
                        end
                    endcase
                end else begin
                    o_cmd.op = OP_SQRT;
                end
            end
            S_DIV: begin
                o_cmd.op = OP_DIV;
                o_cmd.dsrc = r_dix; o_cmd.ddst = r_dix;
                if (!r_dbusy) n_dbusy = 1'b1;
                else if (i_stat.done_iter) begin
                    n_dbusy = 1'b0;
                    o_cmd.op = OP_NONE;
                    if (r_dix == 2'd2) n_state = S_WR;
                    else n_dix = r_dix + 2'd1;
                end
            end
            S_STEP: begin
                if (!i_stat.compliant || w_zero || r_pc == plen(i_order)) n_state = S_WR;
                else begin
                    o_cmd = prog(i_order, r_pc);
                    n_pc = r_pc + 4'd1;
                end
            end
            S_WR: begin
                o_cmd.op = OP_WR;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_pc <= '0; r_dix <= '0; r_dbusy <= 1'b0;
        end else begin
            r_state <= n_state; r_pc <= n_pc; r_dix <= n_dix; r_dbusy <= n_dbusy;
        end
    end
endmodule
